// ===== design/lpc_pkg.sv =====
package lpc_pkg;

    localparam int ENTRIES    = 5;
    localparam int COUNT_BITS = 16;
    localparam int KEY_W      = 64;
    localparam int DATA_W     = 64;
    localparam int SLOT_W     = 3;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    typedef logic [KEY_W-1:0]      t_key;
    typedef logic [DATA_W-1:0]     t_data;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [SLOT_W-1:0]     t_slot;

    typedef struct packed {
        logic start;
        logic step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_status;

endpackage

// ===== design/lpc_ctrl.sv =====
module lpc_ctrl
    import lpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.start  = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_status.last) begin
                    o_cmd.step = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.step   = 1'b1;
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

`ifndef NO_ASSERTIONS
    a_hold_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && i_status.last && !i_status.out_free |=> (r_state == S_SCAN))
        else $error("scan left while result register blocked");

    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_state == S_IDLE) && !o_in_stall)
        else $error("no return to idle after commit");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> (r_state == S_IDLE) && !o_in_stall)
        else $error("start outside idle");
`endif

endmodule

// ===== design/lpc_dp.sv =====
module lpc_dp
    import lpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  logic       i_req_type,
    input  t_key       i_key,
    input  t_data      i_fill_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_hit,
    output t_slot      o_slot,
    output t_data      o_data_out
);

    t_key   r_keys   [ENTRIES];
    t_data  r_data   [ENTRIES];
    t_count r_counts [ENTRIES];

    logic   r_req;
    t_key   r_key;
    t_data  r_fill;
    t_idx   r_idx;
    logic   r_found;
    t_idx   r_match_idx;
    t_data  r_match_data;
    t_count r_match_cnt;
    t_idx   r_best_idx;
    t_count r_best_cnt;

    logic   r_out_valid;
    logic   r_hit;
    t_slot  r_slot;
    t_data  r_data_out;

    t_key   cur_key;
    t_data  cur_data;
    t_count cur_cnt;
    logic   cur_match;
    logic   take_cur;
    logic   sel_found;
    t_idx   sel_match_idx;
    t_data  sel_match_data;
    t_count sel_match_cnt;
    t_idx   sel_best_idx;
    t_count sel_best_cnt;
    t_count sat_cnt;
    t_idx   res_idx;
    logic [IDX_W+SLOT_W-1:0] res_wide;

    assign cur_key   = r_keys[r_idx];
    assign cur_data  = r_data[r_idx];
    assign cur_cnt   = r_counts[r_idx];
    assign cur_match = (cur_key == r_key);
    assign take_cur  = (r_idx == '0) || (cur_cnt < r_best_cnt);

    assign sel_found      = r_found || cur_match;
    assign sel_match_idx  = r_found ? r_match_idx  : r_idx;
    assign sel_match_data = r_found ? r_match_data : cur_data;
    assign sel_match_cnt  = r_found ? r_match_cnt  : cur_cnt;
    assign sel_best_idx   = take_cur ? r_idx   : r_best_idx;
    assign sel_best_cnt   = take_cur ? cur_cnt : r_best_cnt;

    assign sat_cnt  = (sel_match_cnt == '1) ? sel_match_cnt : sel_match_cnt + 1'b1;
    assign res_idx  = (r_req == REQ_INSERT) ? sel_best_idx
                    : (sel_found ? sel_match_idx : '0);
    assign res_wide = {{SLOT_W{1'b0}}, res_idx};

    assign o_status.last     = (r_idx == IDX_W'(ENTRIES - 1));
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    // entry store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_keys[i]   <= '0;
                r_data[i]   <= '0;
                r_counts[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            if (r_req == REQ_INSERT) begin
                r_keys[sel_best_idx]   <= r_key;
                r_data[sel_best_idx]   <= r_fill;
                r_counts[sel_best_idx] <= '0;
            end else if (sel_found) begin
                r_counts[sel_match_idx] <= sat_cnt;
            end
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.step) begin
                r_found <= sel_found;
                if (!o_status.last) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req  <= i_req_type;
            r_key  <= i_key;
            r_fill <= i_fill_data;
        end
        if (i_cmd.step) begin
            r_match_idx  <= sel_match_idx;
            r_match_data <= sel_match_data;
            r_match_cnt  <= sel_match_cnt;
            r_best_idx   <= sel_best_idx;
            r_best_cnt   <= sel_best_cnt;
        end
        if (i_cmd.commit) begin
            r_hit      <= (r_req == REQ_LOOKUP) && sel_found;
            r_slot     <= res_wide[SLOT_W-1:0];
            r_data_out <= (r_req == REQ_INSERT) ? r_fill
                        : (sel_found ? sel_match_data : '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_slot      = r_slot;
    assign o_data_out  = r_data_out;

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_W'(ENTRIES - 1))
        else $error("scan index out of range");

    a_insert_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && (r_req == REQ_INSERT) |=> (r_counts[$past(sel_best_idx)] == '0))
        else $error("replaced entry count not cleared");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("result lost after commit");
`endif

endmodule

// ===== design/lfu_pointer_cache_unit.sv =====
// Fully associative key-to-data cache of ENTRIES entries with least-frequently-used
// replacement. A lookup (req_type 0) returns hit, the slot and its data and bumps that
// entry's saturating hit count; an insert (req_type 1) overwrites the lowest-indexed entry
// with the smallest count and returns its slot and the fill data. Entries reset to key 0
// with no valid bits, so key 0 hits after reset. One item is taken at a time: an accept
// step, then a scan that visits the entries one by one because it reads the entry store
// through a single read port; the last scan step writes the entry and loads the result
// register, and waits there while a previous result is still held.
module lfu_pointer_cache_unit
    import lpc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  logic  i_req_type,
    input  t_key  i_key,
    input  t_data i_fill_data,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    output logic  o_hit,
    output t_slot o_slot,
    output t_data o_data_out
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    lpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    lpc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_req_type  (i_req_type),
        .i_key       (i_key),
        .i_fill_data (i_fill_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_hit       (o_hit),
        .o_slot      (o_slot),
        .o_data_out  (o_data_out)
    );

endmodule
